@@ hw/rtl/life_generation_rows_unit_defines.svh @@
// Assertion helpers, clocked on i_clk and disabled while i_rst_n is low.
`ifndef LIFE_GENERATION_ROWS_UNIT_DEFINES_SVH
`define LIFE_GENERATION_ROWS_UNIT_DEFINES_SVH

// Condition holds in the same cycle as the antecedent.
`define LGR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Condition holds in the cycle after the antecedent.
`define LGR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ hw/rtl/lgr_pkg.sv @@
`timescale 1ns / 1ps
package lgr_pkg;

    localparam int ROW_BITS   = 64;
    localparam int MAX_WIDTH  = 64;
    localparam int WIDTH_BITS = 7;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
    localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

    typedef logic [ROW_BITS-1:0]   t_row;
    typedef logic [WIDTH_BITS-1:0] t_width;
    typedef logic [PTR_BITS-1:0]   t_ptr;
    typedef logic [CNT_BITS-1:0]   t_count;

    typedef struct packed {
        t_row cells;
        logic frame_end;
    } t_result;

    typedef struct packed {
        logic    en0;
        logic    en1;
        t_result d0;
        t_result d1;
    } t_push;

    // Column i is live-capable when i is below the width, saturated at MAX_WIDTH.
    function automatic t_row width_mask(input t_width w);
        t_row m;
        for (int i = 0; i < ROW_BITS; i++) begin
            m[i] = (i < int'(w)) && (i < MAX_WIDTH);
        end
        return m;
    endfunction

endpackage

@@ hw/rtl/life_generation_rows_unit.sv @@
// With the queue empty, the first result a row transaction causes is shown in the
// cycle after the transaction is taken; a final row's second result follows it.
// Throughput: one row per cycle while o_stall is low, set by the 64 parallel cell lanes;
// a final row yields up to two results, which the 4-entry output queue drains one per
// cycle while i_stall is low. Input stalls while fewer than two queue entries are free.
// Reset (synchronous, active low) empties the queue and held rows; width returns to 64.
`timescale 1ns / 1ps
`include "life_generation_rows_unit_defines.svh"
module life_generation_rows_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_row_cells,
    input  logic        i_final_row,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_next_cells,
    output logic        o_frame_end,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata
);

    lgr_pkg::t_row    r_mask;
    lgr_pkg::t_row    r_upper,  n_upper;
    lgr_pkg::t_row    r_middle, n_middle;
    logic [1:0]       r_held,   n_held;
    lgr_pkg::t_row    row_in;
    lgr_pkg::t_row    next_upper_res;
    lgr_pkg::t_row    next_last_res;
    lgr_pkg::t_push   push;
    lgr_pkg::t_result head;
    lgr_pkg::t_count  count;
    logic             in_acc;

    assign o_stall = (count > lgr_pkg::t_count'(lgr_pkg::FIFO_DEPTH - 2));
    assign in_acc  = i_valid && !o_stall;
    assign row_in  = i_row_cells & r_mask;

    // Result for the middle row, and for the incoming row as the bottom one.
    lgr_evolve u_evolve_mid (
        .i_above (r_upper),
        .i_here  (r_middle),
        .i_below (row_in),
        .i_mask  (r_mask),
        .o_next  (next_upper_res)
    );

    lgr_evolve u_evolve_last (
        .i_above (r_middle),
        .i_here  (row_in),
        .i_below ('0),
        .i_mask  (r_mask),
        .o_next  (next_last_res)
    );

    always_comb begin
        push.en0          = in_acc && (r_held != 2'd0);
        push.en1          = in_acc && i_final_row;
        push.d0.cells     = next_upper_res;
        push.d0.frame_end = 1'b0;
        push.d1.cells     = next_last_res;
        push.d1.frame_end = 1'b1;
    end

    always_comb begin
        n_upper  = r_upper;
        n_middle = r_middle;
        n_held   = r_held;
        if (in_acc) begin
            if (i_final_row) begin
                n_upper  = '0;
                n_middle = '0;
                n_held   = 2'd0;
            end else if (r_held == 2'd0) begin
                n_upper  = '0;
                n_middle = row_in;
                n_held   = 2'd1;
            end else begin
                n_upper  = r_middle;
                n_middle = row_in;
                n_held   = 2'd2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= lgr_pkg::width_mask(lgr_pkg::t_width'(lgr_pkg::MAX_WIDTH));
            r_upper  <= '0;
            r_middle <= '0;
            r_held   <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= lgr_pkg::width_mask(i_cfg_wdata);
            end
            r_upper  <= n_upper;
            r_middle <= n_middle;
            r_held   <= n_held;
        end
    end

    lgr_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_data  (head),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_count (count)
    );

    assign o_next_cells = head.cells;
    assign o_frame_end  = head.frame_end;

    `LGR_ASSERT_SAME(a_count_bound, 1'b1, count <= lgr_pkg::t_count'(lgr_pkg::FIFO_DEPTH))
    `LGR_ASSERT_SAME(a_empty_rows_zero, r_held == 2'd0, (r_upper == '0) && (r_middle == '0))
    `LGR_ASSERT_NEXT(a_final_clears, in_acc && i_final_row, r_held == 2'd0)
    `LGR_ASSERT_NEXT(a_push_shows, push.en0 || push.en1, o_valid)

endmodule

@@ hw/rtl/lgr_cell.sv @@
`timescale 1ns / 1ps
module lgr_cell (
    input  logic [2:0] i_above,
    input  logic [2:0] i_here,
    input  logic [2:0] i_below,
    output logic       o_alive
);

    logic [3:0] neighbors;

    always_comb begin
        neighbors = 4'(i_above[0]) + 4'(i_above[1]) + 4'(i_above[2])
                  + 4'(i_here[0])  + 4'(i_here[2])
                  + 4'(i_below[0]) + 4'(i_below[1]) + 4'(i_below[2]);
        o_alive = (neighbors == 4'd3) || ((neighbors == 4'd2) && i_here[1]);
    end

endmodule

@@ hw/rtl/lgr_evolve.sv @@
`timescale 1ns / 1ps
module lgr_evolve (
    input  lgr_pkg::t_row i_above,
    input  lgr_pkg::t_row i_here,
    input  lgr_pkg::t_row i_below,
    input  lgr_pkg::t_row i_mask,
    output lgr_pkg::t_row o_next
);

    // One dead column of padding on each side.
    logic [lgr_pkg::ROW_BITS+1:0] pad_above;
    logic [lgr_pkg::ROW_BITS+1:0] pad_here;
    logic [lgr_pkg::ROW_BITS+1:0] pad_below;
    lgr_pkg::t_row                lanes;

    assign pad_above = {1'b0, i_above & i_mask, 1'b0};
    assign pad_here  = {1'b0, i_here  & i_mask, 1'b0};
    assign pad_below = {1'b0, i_below & i_mask, 1'b0};

    for (genvar c = 0; c < lgr_pkg::ROW_BITS; c++) begin : g_lane
        lgr_cell u_cell (
            .i_above (pad_above[c+2:c]),
            .i_here  (pad_here[c+2:c]),
            .i_below (pad_below[c+2:c]),
            .o_alive (lanes[c])
        );
    end

    assign o_next = lanes & i_mask;

endmodule

@@ hw/rtl/lgr_out_fifo.sv @@
`timescale 1ns / 1ps
module lgr_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lgr_pkg::t_push   i_push,
    output lgr_pkg::t_result o_data,
    output logic             o_valid,
    input  logic             i_stall,
    output lgr_pkg::t_count  o_count
);

    lgr_pkg::t_result r_mem [lgr_pkg::FIFO_DEPTH];
    lgr_pkg::t_ptr    r_wr_ptr, n_wr_ptr;
    lgr_pkg::t_ptr    r_rd_ptr, n_rd_ptr;
    lgr_pkg::t_count  r_count,  n_count;
    lgr_pkg::t_ptr    slot1;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign slot1   = r_wr_ptr + lgr_pkg::t_ptr'(i_push.en0);

    always_comb begin
        n_wr_ptr = r_wr_ptr + lgr_pkg::t_ptr'(i_push.en0) + lgr_pkg::t_ptr'(i_push.en1);
        n_rd_ptr = r_rd_ptr + lgr_pkg::t_ptr'(pop);
        n_count  = r_count + lgr_pkg::t_count'(i_push.en0) + lgr_pkg::t_count'(i_push.en1)
                 - lgr_pkg::t_count'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.en0) begin
            r_mem[r_wr_ptr] <= i_push.d0;
        end
        if (i_push.en1) begin
            r_mem[slot1] <= i_push.d1;
        end
    end

endmodule

@@ test/tb_life_generation_rows_unit.sv @@
`timescale 1ns / 1ps
module tb_life_generation_rows_unit;

    localparam int STALL_LIMIT = 2000;
    localparam int NSTEPS      = 28;
    localparam lgr_pkg::t_row ALL_ONES  = '1;
    localparam lgr_pkg::t_row STRIPES   = 64'haaaa_aaaa_aaaa_aaaa;
    localparam lgr_pkg::t_row EDGE_LIVE = 64'h7fff_ffff_ffff_fffe;

    typedef enum logic {STEP_ROW, STEP_WIDTH} t_step_kind;

    typedef struct packed {
        t_step_kind    kind;
        lgr_pkg::t_row cells;
        logic          fin;
        logic          typed;
        lgr_pkg::t_row want;
    } t_plan_step;

    // Width steps carry the new width in cells.
    localparam t_plan_step PLAN [NSTEPS] = '{
        '{STEP_ROW,   ALL_ONES,               1'b1, 1'b1, EDGE_LIVE},
        '{STEP_ROW,   64'd0,                  1'b1, 1'b1, 64'd0},
        '{STEP_ROW,   64'h8000_0000_0000_0003, 1'b1, 1'b1, 64'd0},
        '{STEP_ROW,   64'h7,                  1'b1, 1'b1, 64'h2},
        '{STEP_ROW,   64'd0,                  1'b0, 1'b0, 64'd0},
        '{STEP_ROW,   64'h7,                  1'b0, 1'b0, 64'd0},
        '{STEP_ROW,   64'd0,                  1'b1, 1'b0, 64'd0},
        '{STEP_ROW,   ALL_ONES,               1'b0, 1'b0, 64'd0},
        '{STEP_ROW,   ALL_ONES,               1'b0, 1'b0, 64'd0},
        '{STEP_ROW,   ALL_ONES,               1'b1, 1'b0, 64'd0},
        '{STEP_ROW,   STRIPES,                1'b0, 1'b0, 64'd0},
        '{STEP_ROW,   ~STRIPES,               1'b0, 1'b0, 64'd0},
        '{STEP_ROW,   STRIPES,                1'b1, 1'b0, 64'd0},
        '{STEP_WIDTH, 64'd0,                  1'b0, 1'b0, 64'd0},
        '{STEP_ROW,   ALL_ONES,               1'b1, 1'b1, 64'd0},
        '{STEP_WIDTH, 64'd127,                1'b0, 1'b0, 64'd0},
        '{STEP_ROW,   ALL_ONES,               1'b1, 1'b1, EDGE_LIVE},
        '{STEP_WIDTH, 64'd3,                  1'b0, 1'b0, 64'd0},
        '{STEP_ROW,   ALL_ONES,               1'b1, 1'b1, 64'h2},
        '{STEP_ROW,   64'h7,                  1'b0, 1'b0, 64'd0},
        '{STEP_ROW,   64'h7,                  1'b0, 1'b0, 64'd0},
        '{STEP_WIDTH, 64'd5,                  1'b0, 1'b0, 64'd0},
        '{STEP_ROW,   ALL_ONES,               1'b1, 1'b0, 64'd0},
        '{STEP_WIDTH, 64'd1,                  1'b0, 1'b0, 64'd0},
        '{STEP_ROW,   ALL_ONES,               1'b1, 1'b1, 64'd0},
        '{STEP_WIDTH, 64'd65,                 1'b0, 1'b0, 64'd0},
        '{STEP_ROW,   64'h8000_0000_0000_0001, 1'b0, 1'b0, 64'd0},
        '{STEP_ROW,   64'hc000_0000_0000_0003, 1'b1, 1'b0, 64'd0}
    };

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    lgr_pkg::t_row   i_row_cells;
    logic            i_final_row;
    logic            o_valid;
    logic            i_stall;
    lgr_pkg::t_row   o_next_cells;
    logic            o_frame_end;
    logic            i_cfg_we;
    lgr_pkg::t_width i_cfg_wdata;

    lgr_pkg::t_result pending_rows[$];
    lgr_pkg::t_row    row_above;
    lgr_pkg::t_row    row_mid;
    logic [1:0]       rows_in;
    lgr_pkg::t_width  width_q;
    int               mismatch_count;
    int               quiet_cycles;
    bit               calm;

    life_generation_rows_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_row_cells  (i_row_cells),
        .i_final_row  (i_final_row),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_next_cells (o_next_cells),
        .o_frame_end  (o_frame_end),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic lgr_pkg::t_row live_columns(input lgr_pkg::t_width w);
        lgr_pkg::t_row m;
        int            lim;
        lim = (int'(w) > lgr_pkg::MAX_WIDTH) ? lgr_pkg::MAX_WIDTH : int'(w);
        for (int i = 0; i < lgr_pkg::ROW_BITS; i++) begin
            m[i] = (i < lim);
        end
        return m;
    endfunction

    function automatic lgr_pkg::t_row next_generation(input lgr_pkg::t_row above,
                                                      input lgr_pkg::t_row here,
                                                      input lgr_pkg::t_row below,
                                                      input lgr_pkg::t_row live);
        lgr_pkg::t_row a;
        lgr_pkg::t_row h;
        lgr_pkg::t_row b;
        lgr_pkg::t_row res;
        int            n;
        a = above & live;
        h = here & live;
        b = below & live;
        res = '0;
        for (int c = 0; c < lgr_pkg::ROW_BITS; c++) begin
            n = 0;
            for (int d = -1; d <= 1; d++) begin
                if (c + d >= 0 && c + d < lgr_pkg::ROW_BITS) begin
                    n += int'(a[c+d]) + int'(b[c+d]);
                    if (d != 0) n += int'(h[c+d]);
                end
            end
            res[c] = (n == 3) || (n == 2 && h[c]);
        end
        return res & live;
    endfunction

    task automatic step_life_row(input lgr_pkg::t_row cells, input logic fin);
        lgr_pkg::t_row live;
        lgr_pkg::t_row r;
        live = live_columns(width_q);
        r = cells & live;
        if (rows_in == 2'd0) begin
            if (fin) begin
                pending_rows.push_back('{cells: next_generation('0, r, '0, live),
                                         frame_end: 1'b1});
            end else begin
                row_above = '0;
                row_mid = r;
                rows_in = 2'd1;
            end
        end else begin
            pending_rows.push_back('{cells: next_generation(row_above, row_mid, r, live),
                                     frame_end: 1'b0});
            row_above = row_mid;
            row_mid = r;
            rows_in = 2'd2;
            if (fin) begin
                pending_rows.push_back('{cells: next_generation(row_above, row_mid, '0, live),
                                         frame_end: 1'b1});
                row_above = '0;
                row_mid = '0;
                rows_in = 2'd0;
            end
        end
    endtask

    // Hold the row until the transaction is taken; decided on stable values at negedge.
    task automatic send_row(input lgr_pkg::t_row cells, input logic fin, input logic typed,
                            input lgr_pkg::t_row want);
        i_valid <= 1'b1;
        i_row_cells <= cells;
        i_final_row <= fin;
        do @(negedge i_clk); while (o_stall);
        if (typed) pending_rows.push_back('{cells: want, frame_end: 1'b1});
        else step_life_row(cells, fin);
        @(posedge i_clk);
    endtask

    task automatic pause_input(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic write_width(input lgr_pkg::t_width w);
        i_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        width_q = w;
    endtask

    task automatic flag_result(input string why, input lgr_pkg::t_result want,
                               input lgr_pkg::t_result got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%s: expected cells=%h end=%b, got cells=%h end=%b",
                     why, want.cells, want.frame_end, got.cells, got.frame_end);
        end
    endtask

    function automatic lgr_pkg::t_row random_row();
        lgr_pkg::t_row r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0: r = '0;
            1: r = '1;
            2: r = r & {$urandom, $urandom} & {$urandom, $urandom};
            3: r = r | {$urandom, $urandom};
            4: r = lgr_pkg::t_row'(1) << $urandom_range(0, lgr_pkg::ROW_BITS - 1);
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (calm || $urandom_range(0, 2) != 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(0, 19)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat ($urandom_range(0, 9)) @(posedge i_clk);
            end
        end
    end

    initial begin
        lgr_pkg::t_result want;
        lgr_pkg::t_result got;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.cells = o_next_cells;
                got.frame_end = o_frame_end;
                if (pending_rows.size() == 0) begin
                    flag_result("unexpected row", '0, got);
                end else begin
                    want = pending_rows.pop_front();
                    if (got.cells !== want.cells || got.frame_end !== want.frame_end)
                        flag_result("row mismatch", want, got);
                end
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(negedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb_life_generation_rows_unit NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int              frame_left;
        int              count;
        lgr_pkg::t_width w;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_row_cells = '0;
        i_final_row = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        row_above = '0;
        row_mid = '0;
        rows_in = 2'd0;
        width_q = lgr_pkg::t_width'(lgr_pkg::MAX_WIDTH);
        mismatch_count = 0;
        calm = 1'b0;
        frame_left = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < NSTEPS; k++) begin
            if (PLAN[k].kind == STEP_WIDTH) begin
                write_width(PLAN[k].cells[lgr_pkg::WIDTH_BITS-1:0]);
            end else begin
                send_row(PLAN[k].cells, PLAN[k].fin, PLAN[k].typed, PLAN[k].want);
                if ($urandom_range(0, 2) == 0) pause_input($urandom_range(1, 10));
            end
        end

        // Phases may end mid-frame, so some width changes land on held rows.
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: w = lgr_pkg::t_width'($urandom_range(2, 63));
                1: w = 7'd127;
                2: w = 7'd1;
                3: w = lgr_pkg::t_width'($urandom_range(0, 127));
                4: w = 7'd0;
                5: w = lgr_pkg::t_width'($urandom_range(3, 64));
                6: w = 7'd65;
                default: w = 7'd64;
            endcase
            if (p == 7) calm = 1'b1;
            write_width(w);
            count = (p == 4) ? 40 : 190;
            for (int i = 0; i < count; i++) begin
                if (frame_left == 0) begin
                    frame_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                             : $urandom_range(1, 6);
                end
                send_row(random_row(), frame_left == 1, 1'b0, '0);
                frame_left--;
                if (!calm && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 10));
            end
        end

        i_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_life_generation_rows_unit OK");
        end else begin
            $display("tb_life_generation_rows_unit NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/lgr_pkg.sv
hw/rtl/lgr_cell.sv
hw/rtl/lgr_evolve.sv
hw/rtl/lgr_out_fifo.sv
hw/rtl/life_generation_rows_unit.sv
test/tb_life_generation_rows_unit.sv
